>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dcwb_pkg.sv
// ----------------------------------------------------------------------------
// dcwb_pkg
// Types, codes and reset values of the drive command watchdog brake unit.
// ----------------------------------------------------------------------------
package dcwb_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TICK_W      = 16;
    localparam int DUTY_W      = 8;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET     = 16'd500;
    localparam logic [TICK_W-1:0] BRAKE_PULSE_RESET = 16'd60;
    localparam logic [DUTY_W-1:0] DRIVE_DUTY_RESET  = 8'd49;
    localparam logic [DUTY_W-1:0] TURN_DUTY_RESET   = 8'd32;
    localparam logic [DUTY_W-1:0] BRAKE_DUTY_RESET  = 8'd20;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_F       = 8'h46;
    localparam logic [7:0] CHAR_B       = 8'h42;
    localparam logic [7:0] CHAR_L       = 8'h4C;
    localparam logic [7:0] CHAR_R       = 8'h52;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMEOUT     = 3'd0,
        REG_BRAKE_PULSE = 3'd1,
        REG_DRIVE_DUTY  = 3'd2,
        REG_TURN_DUTY   = 3'd3,
        REG_BRAKE_DUTY  = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        CMD_STOP  = 3'd0,
        CMD_FWD   = 3'd1,
        CMD_BACK  = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_RIGHT = 3'd4,
        CMD_NONE  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_BRAKE = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_REV   = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        TRAVEL_STOP = 2'd0,
        TRAVEL_FWD  = 2'd1,
        TRAVEL_BACK = 2'd2
    } travel_t;

    typedef struct packed {
        logic [1:0]        left_drive;
        logic [1:0]        right_drive;
        logic [DUTY_W-1:0] pwm_duty;
        logic [2:0]        active_command;
        logic              braking;
    } drive_result_t;

endpackage

>>> hdl/dcwb_core.sv
// ----------------------------------------------------------------------------
// dcwb_core
// Configuration registers, command decode, watchdog and counter-brake state.
// Produces the result of the item being taken in the same cycle.
// ----------------------------------------------------------------------------
module dcwb_core #(
    parameter int COUNT_WIDTH = dcwb_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dcwb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dcwb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_take,
    input  logic                                op,
    input  logic [7:0]                          rx_byte,
    output dcwb_pkg::drive_result_t             result
);
    import dcwb_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [TICK_W-1:0] timeout_reg;
    logic [TICK_W-1:0] brake_pulse_reg;
    logic [DUTY_W-1:0] drive_duty_reg;
    logic [DUTY_W-1:0] turn_duty_reg;
    logic [DUTY_W-1:0] brake_duty_reg;

    cmd_t              requested_reg, requested_next;
    cmd_t              applied_reg, applied_next;
    travel_t           travel_reg, travel_next;
    logic [COUNT_WIDTH-1:0] idle_reg, idle_next;
    logic [COUNT_WIDTH-1:0] pulse_reg, pulse_next;
    dir_t              left_reg, left_next;
    dir_t              right_reg, right_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;

    logic [7:0]        folded;
    cmd_t              decoded;
    logic [COUNT_WIDTH-1:0] idle_inc;
    logic [COUNT_WIDTH-1:0] pulse_len;
    cmd_t              req_eff;

    // Configuration writes; unknown indexes fall through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            brake_pulse_reg <= BRAKE_PULSE_RESET;
            drive_duty_reg  <= DRIVE_DUTY_RESET;
            turn_duty_reg   <= TURN_DUTY_RESET;
            brake_duty_reg  <= BRAKE_DUTY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:     timeout_reg     <= cfg_data;
                REG_BRAKE_PULSE: brake_pulse_reg <= cfg_data;
                REG_DRIVE_DUTY:  drive_duty_reg  <= cfg_data[DUTY_W-1:0];
                REG_TURN_DUTY:   turn_duty_reg   <= cfg_data[DUTY_W-1:0];
                REG_BRAKE_DUTY:  brake_duty_reg  <= cfg_data[DUTY_W-1:0];
                default:         ;
            endcase
        end
    end

    // Fold to upper case, then map the five command letters.
    always_comb
    begin
        if (rx_byte >= CHAR_LOWER_A && rx_byte <= CHAR_LOWER_Z)
            folded = rx_byte - CASE_OFFSET;
        else
            folded = rx_byte;
        unique case (folded)
            CHAR_S:  decoded = CMD_STOP;
            CHAR_F:  decoded = CMD_FWD;
            CHAR_B:  decoded = CMD_BACK;
            CHAR_L:  decoded = CMD_LEFT;
            CHAR_R:  decoded = CMD_RIGHT;
            default: decoded = CMD_NONE;
        endcase
    end

    always_comb
    begin
        idle_inc = (idle_reg == COUNT_MAX) ? idle_reg : idle_reg + 1'b1;
        if (CMP_W'(brake_pulse_reg) > CMP_W'(COUNT_MAX))
            pulse_len = COUNT_MAX;
        else
            pulse_len = COUNT_WIDTH'(brake_pulse_reg);
        if (CMP_W'(idle_inc) > CMP_W'(timeout_reg))
            req_eff = CMD_STOP;
        else
            req_eff = requested_reg;
    end

    always_comb
    begin
        requested_next = requested_reg;
        applied_next   = applied_reg;
        travel_next    = travel_reg;
        idle_next      = idle_reg;
        pulse_next     = pulse_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        duty_next      = duty_reg;

        if (item_take)
        begin
            if (op)
            begin
                if (decoded != CMD_NONE)
                begin
                    requested_next = decoded;
                    idle_next      = '0;
                end
            end
            else
            begin
                idle_next = idle_inc;
                if (pulse_reg != '0)
                begin
                    pulse_next = pulse_reg - 1'b1;
                    // pulse over: plain brake
                    if (pulse_reg == COUNT_WIDTH'(1))
                    begin
                        left_next  = DIR_BRAKE;
                        right_next = DIR_BRAKE;
                        duty_next  = '0;
                    end
                end
                else
                begin
                    requested_next = req_eff;
                    if (req_eff != applied_reg)
                    begin
                        applied_next = req_eff;
                        if (req_eff == CMD_STOP &&
                            (travel_reg == TRAVEL_FWD || travel_reg == TRAVEL_BACK))
                        begin
                            if (pulse_len == '0)
                            begin
                                left_next  = DIR_BRAKE;
                                right_next = DIR_BRAKE;
                                duty_next  = '0;
                            end
                            else
                            begin
                                // drive against the last travel direction
                                left_next  = (travel_reg == TRAVEL_FWD) ? DIR_REV : DIR_FWD;
                                right_next = (travel_reg == TRAVEL_FWD) ? DIR_REV : DIR_FWD;
                                duty_next  = brake_duty_reg;
                                pulse_next = pulse_len;
                            end
                        end
                        else
                        begin
                            unique case (req_eff)
                                CMD_FWD:
                                begin
                                    left_next  = DIR_FWD;
                                    right_next = DIR_FWD;
                                    duty_next  = drive_duty_reg;
                                end
                                CMD_BACK:
                                begin
                                    left_next  = DIR_REV;
                                    right_next = DIR_REV;
                                    duty_next  = drive_duty_reg;
                                end
                                CMD_RIGHT:
                                begin
                                    left_next  = DIR_FWD;
                                    right_next = DIR_REV;
                                    duty_next  = turn_duty_reg;
                                end
                                CMD_LEFT:
                                begin
                                    left_next  = DIR_REV;
                                    right_next = DIR_FWD;
                                    duty_next  = turn_duty_reg;
                                end
                                default:
                                begin
                                    left_next  = DIR_BRAKE;
                                    right_next = DIR_BRAKE;
                                    duty_next  = '0;
                                end
                            endcase
                        end
                        if (req_eff == CMD_FWD)
                            travel_next = TRAVEL_FWD;
                        else if (req_eff == CMD_BACK)
                            travel_next = TRAVEL_BACK;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_reg <= CMD_STOP;
            applied_reg   <= CMD_NONE;
            travel_reg    <= TRAVEL_STOP;
            idle_reg      <= '0;
            pulse_reg     <= '0;
            left_reg      <= DIR_BRAKE;
            right_reg     <= DIR_BRAKE;
            duty_reg      <= '0;
        end
        else
        begin
            requested_reg <= requested_next;
            applied_reg   <= applied_next;
            travel_reg    <= travel_next;
            idle_reg      <= idle_next;
            pulse_reg     <= pulse_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            duty_reg      <= duty_next;
        end
    end

    always_comb
    begin
        result.left_drive     = left_next;
        result.right_drive    = right_next;
        result.pwm_duty       = duty_next;
        result.active_command = (applied_next == CMD_NONE) ? CMD_STOP : applied_next;
        result.braking        = (pulse_next != '0);
    end

endmodule

>>> hdl/drive_command_watchdog_brake_unit.sv
// ----------------------------------------------------------------------------
// drive_command_watchdog_brake_unit
// Differential-drive command controller with watchdog stop and counter-brake.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  cmd      | cmd_valid/cmd_stall | op, rx_byte
//  res      | res_valid/res_stall | left_drive, right_drive, pwm_duty,
//           |                     | active_command, braking
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per clock while cmd_stall is low; its result is registered in the
// output register, or in the skid entry if that register is full and stalled.
// The state update for an item is a single pass at the accept edge. A
// two-entry result buffer (output register plus skid) lets items keep flowing
// while the result side stalls; cmd_stall rises only when both entries are
// full. Asynchronous reset needs no clearing pass; cfg_ready is always high.
module drive_command_watchdog_brake_unit #(
    parameter int COUNT_WIDTH = dcwb_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic                              op,
    input  logic [7:0]                        rx_byte,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [1:0]                        left_drive,
    output logic [1:0]                        right_drive,
    output logic [dcwb_pkg::DUTY_W-1:0]       pwm_duty,
    output logic [2:0]                        active_command,
    output logic                              braking,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcwb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dcwb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dcwb_pkg::*;

    logic          cmd_take;
    logic          res_take;
    drive_result_t new_result;

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    drive_result_t out_data_reg, out_data_next;
    drive_result_t skid_data_reg, skid_data_next;

    assign cfg_ready = 1'b1;
    assign cmd_stall = skid_valid_reg;
    assign cmd_take  = cmd_valid && !skid_valid_reg;
    assign res_take  = out_valid_reg && !res_stall;

    dcwb_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_take (cmd_take),
        .op        (op),
        .rx_byte   (rx_byte),
        .result    (new_result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (cmd_take)
        begin
            // skid is empty here
            if (!out_valid_reg || res_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = new_result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = new_result;
            end
        end
        else if (res_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
                out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res_valid      = out_valid_reg;
    assign left_drive     = out_data_reg.left_drive;
    assign right_drive    = out_data_reg.right_drive;
    assign pwm_duty       = out_data_reg.pwm_duty;
    assign active_command = out_data_reg.active_command;
    assign braking        = out_data_reg.braking;

endmodule

>>> hdl/dcwb_checker.sv
// ----------------------------------------------------------------------------
// dcwb_checker
// Port-level checks of the drive command watchdog brake unit, bound to it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcwb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_stall,
    input logic       res_valid,
    input logic       res_stall,
    input logic [1:0] left_drive,
    input logic [1:0] right_drive,
    input logic [7:0] pwm_duty,
    input logic [2:0] active_command,
    input logic       braking
);
    import dcwb_pkg::*;

    logic in_take;
    logic stop_shown;
    logic out_stop;
    logic out_sym;
    logic out_fwd;

    assign in_take    = cmd_valid && !cmd_stall;
    assign stop_shown = res_valid && active_command == CMD_STOP && !braking;
    // both sides brake with duty zero
    assign out_stop   = left_drive == DIR_BRAKE && right_drive == DIR_BRAKE && pwm_duty == '0;
    assign out_sym    = left_drive == right_drive && left_drive != DIR_BRAKE;
    assign out_fwd    = left_drive == DIR_FWD && right_drive == DIR_FWD && !braking;

    `CHK_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped while stalled")

    `CHK_NEXT(a_item_out, in_take && !res_valid, res_valid, "taken item gave no result")

    `CHK_IMPL(a_brake_dir, res_valid && braking, out_sym, "counter-brake drive not symmetric")

    `CHK_IMPL(a_stop_idle, stop_shown, out_stop, "stop without brake outputs")

    `CHK_IMPL(a_fwd_dir, res_valid && active_command == CMD_FWD, out_fwd, "forward drive mismatch")

endmodule

bind drive_command_watchdog_brake_unit dcwb_checker u_dcwb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .left_drive     (left_drive),
    .right_drive    (right_drive),
    .pwm_duty       (pwm_duty),
    .active_command (active_command),
    .braking        (braking)
);
